// ===== rtl/core/rbst_pkg.sv =====
// Package with the types, constants and divider step of the ray-box slab test.
`default_nettype none
package rbst_pkg;

    localparam int FRAC_BITS = 16;
    localparam int Q_BITS    = 31;
    localparam int NUM_LANES = 6;
    localparam int DIV_STAGES = Q_BITS;
    localparam logic [30:0] T_SAT = 31'h7FFF_FFFF;

    localparam logic CFG_NEAR_ZERO = 1'b0;
    localparam logic CFG_FAR_T     = 1'b1;

    typedef struct packed {
        logic [32:0] rem;
        logic [30:0] quo;
        logic [30:0] dlow;
        logic [31:0] adir;
        logic        sat;
        logic        par;
        logic        neg;
        logic        nz;
        logic        npos;
    } lane_t;

    function automatic lane_t div_step(input lane_t l);
        lane_t       r;
        logic [32:0] rem2;
        r    = l;
        rem2 = {l.rem[31:0], l.dlow[30]};
        r.dlow = {l.dlow[29:0], 1'b0};
        if (rem2 >= {1'b0, l.adir})
        begin
            r.rem = rem2 - {1'b0, l.adir};
            r.quo = {l.quo[29:0], 1'b1};
        end
        else
        begin
            r.rem = rem2;
            r.quo = {l.quo[29:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ray_box_slab_test_core.sv =====
// Top level of the pipelined ray against axis-aligned box slab test.
//
// An item (ray origin, direction and box corners, signed fixed point) is
// accepted at a rising clock edge where start is high and busy is low.
// Busy is never raised, so one item may be accepted in every cycle.
// Six restoring dividers, one bit of quotient per pipeline stage, compute
// the crossing times of the two box planes on each axis.
// The item passes 35 register stages: one entry stage, 31 divider stages,
// one time stage, one ordering stage and one compare stage. The first is
// loaded at the accepting edge, and hit_valid is high for exactly one cycle
// once the item's result is loaded into the compare stage, where it is taken.
// Throughput is one item per cycle, set by the fully pipelined dividers.
// Results leave in the order that items arrived; the receiver cannot stall.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// is always ready and should be written only while no item is in flight.
// Reset clears all valid bits and restores near_zero_limit to 7 and
// far_t to its maximum value.
`default_nettype none
module ray_box_slab_test_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] origin_x,
    input  wire logic [31:0] origin_y,
    input  wire logic [31:0] origin_z,
    input  wire logic [31:0] dir_x,
    input  wire logic [31:0] dir_y,
    input  wire logic [31:0] dir_z,
    input  wire logic [31:0] box_lo_x,
    input  wire logic [31:0] box_lo_y,
    input  wire logic [31:0] box_lo_z,
    input  wire logic [31:0] box_hi_x,
    input  wire logic [31:0] box_hi_y,
    input  wire logic [31:0] box_hi_z,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [30:0] cfg_data,
    output logic             hit,
    output logic             hit_valid
);

    localparam int F = rbst_pkg::FRAC_BITS;
    localparam int L = rbst_pkg::NUM_LANES;
    localparam int S = rbst_pkg::DIV_STAGES;

    logic [15:0] near_zero_limit_reg;
    logic [30:0] far_t_reg;

    rbst_pkg::lane_t entry_next [L];
    rbst_pkg::lane_t pipe_reg [S+1][L];
    rbst_pkg::lane_t step_next [S][L];
    logic [S:0]      pv_reg;

    logic [31:0] t_next [L];
    logic [31:0] t_reg [L];
    logic        tv_reg;

    logic [31:0] lo_next [3];
    logic [31:0] hi_next [3];
    logic [31:0] lo_reg [3];
    logic [31:0] hi_reg [3];
    logic        ov_reg;

    logic        hit_next;
    logic        hit_reg;
    logic        hv_reg;

    logic [31:0] org [3];
    logic [31:0] dir [3];
    logic [31:0] bnd [L];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign hit       = hit_reg;
    assign hit_valid = hv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_zero_limit_reg <= 16'd7;
            far_t_reg           <= rbst_pkg::T_SAT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rbst_pkg::CFG_NEAR_ZERO: near_zero_limit_reg <= cfg_data[15:0];
                rbst_pkg::CFG_FAR_T:     far_t_reg <= cfg_data;
                default:                 far_t_reg <= far_t_reg;
            endcase
        end
    end

    always_comb
    begin
        logic [32:0] num;
        logic [32:0] anum;
        logic [31:0] adir;
        logic [32+F:0] dvd;
        org[0] = origin_x; org[1] = origin_y; org[2] = origin_z;
        dir[0] = dir_x;    dir[1] = dir_y;    dir[2] = dir_z;
        bnd[0] = box_lo_x; bnd[1] = box_hi_x;
        bnd[2] = box_lo_y; bnd[3] = box_hi_y;
        bnd[4] = box_lo_z; bnd[5] = box_hi_z;
        for (int i = 0; i < L; i++)
        begin
            num  = {bnd[i][31], bnd[i]} - {org[i/2][31], org[i/2]};
            anum = num[32] ? (33'd0 - num) : num;
            adir = dir[i/2][31] ? (32'd0 - dir[i/2]) : dir[i/2];
            dvd  = {anum, {F{1'b0}}};
            entry_next[i].rem  = 33'(dvd[32+F:31]);
            entry_next[i].dlow = dvd[30:0];
            entry_next[i].quo  = '0;
            entry_next[i].adir = adir;
            entry_next[i].sat  = 1'b0;
            entry_next[i].par  = (adir == 32'd0) || (adir < {16'd0, near_zero_limit_reg});
            entry_next[i].neg  = num[32] != dir[i/2][31];
            entry_next[i].nz   = num != 33'd0;
            entry_next[i].npos = !num[32];
        end
    end

    always_comb
    begin
        for (int s = 0; s < S; s++)
        begin
            for (int i = 0; i < L; i++)
            begin
                step_next[s][i] = rbst_pkg::div_step(pipe_reg[s][i]);
                if (s == 0)
                begin
                    step_next[s][i].sat = pipe_reg[s][i].rem >= {1'b0, pipe_reg[s][i].adir};
                end
            end
        end
    end

    always_comb
    begin
        logic [30:0] mag;
        logic        ng;
        for (int i = 0; i < L; i++)
        begin
            if (pipe_reg[S][i].par)
            begin
                mag = pipe_reg[S][i].nz ? far_t_reg : 31'd0;
                ng  = !pipe_reg[S][i].npos;
            end
            else
            begin
                mag = pipe_reg[S][i].sat ? rbst_pkg::T_SAT : pipe_reg[S][i].quo;
                ng  = pipe_reg[S][i].neg;
            end
            t_next[i] = ng ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if ($signed(t_reg[2*a]) > $signed(t_reg[2*a+1]))
            begin
                lo_next[a] = t_reg[2*a+1];
                hi_next[a] = t_reg[2*a];
            end
            else
            begin
                lo_next[a] = t_reg[2*a];
                hi_next[a] = t_reg[2*a+1];
            end
        end
    end

    always_comb
    begin
        logic signed [31:0] tmin;
        logic signed [31:0] tmax;
        logic signed [31:0] fmin;
        logic signed [31:0] fmax;
        logic               rej_xy;
        logic               rej_z;
        rej_xy = ($signed(lo_reg[0]) > $signed(hi_reg[1]))
              || ($signed(lo_reg[1]) > $signed(hi_reg[0]));
        tmin = ($signed(lo_reg[0]) > $signed(lo_reg[1])) ? lo_reg[0] : lo_reg[1];
        tmax = ($signed(hi_reg[0]) < $signed(hi_reg[1])) ? hi_reg[0] : hi_reg[1];
        rej_z = ($signed(lo_reg[2]) > tmax) || ($signed(hi_reg[2]) < tmin);
        fmin = ($signed(lo_reg[2]) > tmin) ? lo_reg[2] : tmin;
        fmax = ($signed(hi_reg[2]) < tmax) ? hi_reg[2] : tmax;
        hit_next = !rej_xy && !rej_z && (fmax > fmin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
            tv_reg <= 1'b0;
            ov_reg <= 1'b0;
            hv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= {pv_reg[S-1:0], start && !busy};
            tv_reg <= pv_reg[S];
            ov_reg <= tv_reg;
            hv_reg <= ov_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < L; i++)
        begin
            pipe_reg[0][i] <= entry_next[i];
            for (int s = 0; s < S; s++)
            begin
                pipe_reg[s+1][i] <= step_next[s][i];
            end
            t_reg[i] <= t_next[i];
        end
        for (int a = 0; a < 3; a++)
        begin
            lo_reg[a] <= lo_next[a];
            hi_reg[a] <= hi_next[a];
        end
        hit_reg <= hit_next;
    end

endmodule
`default_nettype wire
